FILE: sv/sdro_pkg.sv
// ----------------------------------------------------------------------------
// sdro_pkg - shared types and constants of the SCAN request ordering core
// Word layouts of both channels, the queue entry that the front end hands to
// the back end, the sequencer states and the register map.
// ----------------------------------------------------------------------------
`default_nettype none

package sdro_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned SUM_W  = 22;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Register map, index is paddr[3:2]
  localparam logic [1:0] REG_START_POS = 2'd0;
  localparam logic [1:0] REG_SWEEP_UP  = 2'd1;
  localparam logic [1:0] REG_FAR_END   = 2'd2;

  localparam logic [POS_W-1:0] START_POS_RST = 16'd35;
  localparam logic             SWEEP_UP_RST  = 1'b0;
  localparam logic [POS_W-1:0] FAR_END_RST   = 16'd100;

  typedef struct packed {
    logic [POS_W-1:0] cylinder;
    logic             batch_end;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [SUM_W-1:0] seek_total;
    logic             path_end;
  } out_word_t;

  // One visit of the path, passed from the sequencer to the seek accumulator
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             first;
    logic             last;
  } visit_t;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_SPLIT = 6'b000010,
    ST_FIRST = 6'b000100,
    ST_SIDE1 = 6'b001000,
    ST_TURN  = 6'b010000,
    ST_SIDE2 = 6'b100000
  } seq_state_e;

endpackage

`default_nettype wire

FILE: sv/sdro_front.sv
// ----------------------------------------------------------------------------
// sdro_front - request intake, insertion sort and path sequencer
// Keeps the batch in a sorted row of cells, splits it at the start position
// and walks the visit order into the queue, one visit per cycle unless full.
// ----------------------------------------------------------------------------
`default_nettype none

module sdro_front #(
  parameter int unsigned MAX_REQUESTS = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_stall_o,
  input  wire sdro_pkg::in_word_t         in_word_i,
  input  wire logic [sdro_pkg::POS_W-1:0] start_pos_i,
  input  wire logic                       sweep_up_i,
  input  wire logic [sdro_pkg::POS_W-1:0] far_end_i,
  output      logic                       push_o,
  output      sdro_pkg::visit_t           visit_o,
  input  wire logic                       full_i
);

  localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  logic [sdro_pkg::POS_W-1:0] row_q [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0]    gt, below;
  logic [CW-1:0]              cnt_q, cnt_d, nleft_q, nleft_d, idx_q, idx_d;
  logic                       desc_q, desc_d;
  sdro_pkg::seq_state_e       state_q, state_d;
  logic                       accept, ins_en;
  logic                       at_end, other_empty, side1_full;
  logic [sdro_pkg::POS_W-1:0] rd_pos;

  assign accept = in_valid_i && !in_stall_o;
  assign ins_en = accept && (cnt_q < CW'(MAX_REQUESTS));
  assign in_stall_o = (state_q != sdro_pkg::ST_LOAD);

  always_comb begin
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      gt[i]    = (CW'(i) < cnt_q) && (row_q[i] > in_word_i.cylinder);
      below[i] = (CW'(i) < cnt_q) && (row_q[i] < start_pos_i);
    end
  end

  // Each cell keeps, takes the new word, or takes its lower neighbor
  for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
    logic shift_in;
    if (g == 0) begin : g_first
      assign shift_in = 1'b0;
    end else begin : g_rest
      assign shift_in = gt[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (ins_en) begin
        if (shift_in) begin
          row_q[g] <= row_q[(g > 0) ? g - 1 : 0];
        end else if (gt[g] || (CW'(g) == cnt_q)) begin
          row_q[g] <= in_word_i.cylinder;
        end
      end
    end
  end

  assign rd_pos = row_q[idx_q[IW-1:0]];
  assign at_end = desc_q ? (idx_q == '0) : (idx_q == cnt_q - CW'(1));
  assign other_empty = desc_q ? (nleft_q == cnt_q) : (nleft_q == '0);
  assign side1_full = sweep_up_i ? (nleft_q != cnt_q) : (nleft_q != '0);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    nleft_d = nleft_q;
    idx_d   = idx_q;
    desc_d  = desc_q;
    push_o  = 1'b0;
    visit_o = '{position: rd_pos, first: 1'b0, last: 1'b0};
    case (state_q)
      sdro_pkg::ST_LOAD: begin
        if (ins_en) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (accept && in_word_i.batch_end) begin
          state_d = sdro_pkg::ST_SPLIT;
        end
      end
      sdro_pkg::ST_SPLIT: begin
        nleft_d = CW'($countones(below));
        state_d = sdro_pkg::ST_FIRST;
      end
      sdro_pkg::ST_FIRST: begin
        visit_o = '{position: start_pos_i, first: 1'b1, last: 1'b0};
        if (!full_i) begin
          push_o = 1'b1;
          desc_d = !sweep_up_i;
          idx_d  = sweep_up_i ? nleft_q : nleft_q - CW'(1);
          state_d = side1_full ? sdro_pkg::ST_SIDE1 : sdro_pkg::ST_TURN;
        end
      end
      sdro_pkg::ST_SIDE1, sdro_pkg::ST_SIDE2: begin
        visit_o.last = at_end && ((state_q == sdro_pkg::ST_SIDE2) || other_empty);
        if (!full_i) begin
          push_o = 1'b1;
          if (!at_end) begin
            idx_d = desc_q ? idx_q - CW'(1) : idx_q + CW'(1);
          end else if ((state_q == sdro_pkg::ST_SIDE1) && !other_empty) begin
            state_d = sdro_pkg::ST_TURN;
          end else begin
            cnt_d   = '0;
            state_d = sdro_pkg::ST_LOAD;
          end
        end
      end
      sdro_pkg::ST_TURN: begin
        visit_o.position = sweep_up_i ? far_end_i : '0;
        if (!full_i) begin
          push_o  = 1'b1;
          desc_d  = sweep_up_i;
          idx_d   = sweep_up_i ? nleft_q - CW'(1) : nleft_q;
          state_d = sdro_pkg::ST_SIDE2;
        end
      end
      default: begin
        state_d = sdro_pkg::ST_LOAD;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdro_pkg::ST_LOAD;
      cnt_q   <= '0;
      nleft_q <= '0;
      idx_q   <= '0;
      desc_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nleft_q <= nleft_d;
      idx_q   <= idx_d;
      desc_q  <= desc_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sdro_queue.sv
// ----------------------------------------------------------------------------
// sdro_queue - two-entry queue of visits
// Decouples the path sequencer from the seek accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module sdro_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sdro_pkg::visit_t visit_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      sdro_pkg::visit_t visit_o,
  output      logic             empty_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sdro_pkg::visit_t entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] fill_q;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == CNT_W'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign visit_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= visit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + CNT_W'(1);
        2'b01:   fill_q <= fill_q - CNT_W'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/sdro_back.sv
// ----------------------------------------------------------------------------
// sdro_back - seek accumulator and output register
// Moves the head to each visit, adds the travel to a saturating sum and
// holds the result word until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sdro_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sdro_pkg::visit_t  visit_i,
  input  wire logic              empty_i,
  output      logic              pop_o,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      sdro_pkg::out_word_t out_word_o
);

  logic [sdro_pkg::POS_W-1:0] head_q, diff;
  logic [sdro_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [sdro_pkg::SUM_W:0]   sum_wide;
  logic                       valid_q;
  sdro_pkg::out_word_t        word_q;

  assign pop_o = !empty_i && (!valid_q || !out_stall_i);
  assign diff  = (visit_i.position > head_q) ? visit_i.position - head_q
                                             : head_q - visit_i.position;
  assign sum_wide = {1'b0, sum_q} + (sdro_pkg::SUM_W + 1)'(diff);

  always_comb begin
    if (visit_i.first) begin
      sum_d = '0;
    end else if (sum_wide[sdro_pkg::SUM_W]) begin
      sum_d = sdro_pkg::SUM_MAX;
    end else begin
      sum_d = sum_wide[sdro_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      head_q  <= '0;
      sum_q   <= '0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        head_q  <= visit_i.position;
        sum_q   <= sum_d;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      word_q <= '{position: visit_i.position, seek_total: sum_d, path_end: visit_i.last};
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

FILE: sv/scan_disk_request_order_core.sv
// ----------------------------------------------------------------------------
// scan_disk_request_order_core - SCAN (elevator) ordering of disk requests
// Collects a batch of cylinder requests and emits the head's visit path
// with the running seek distance.
// ----------------------------------------------------------------------------
// Requests enter one word per cycle while the input does not stall; the
// word with batch_end set closes the batch. Up to MAX_REQUESTS requests
// are kept in ascending order as they arrive, so no separate sort pass
// runs; later requests of a full batch are dropped, but a dropped closing
// word still starts scheduling. After the closing word the input stalls,
// the batch is split at start_position (requests equal to it count as the
// upper side), then the sequencer emits one visit per cycle while the queue
// has room: the start position, the first side in sweep order, the
// turnaround point (0 sweeping down, far_end sweeping up) if the other side
// has requests, then the other side. Stalls on the result side hold the
// emission once the queue fills. The input accepts the next batch once the
// last visit is queued.
// Each result word carries the position, the seek total so far (0 on the
// first word, saturating at its maximum) and path_end on the last word.
// A two-entry queue and an output register let the consumer stall without
// losing words. Registers (APB, 32-bit data): start_position at 0x0,
// sweep_up_first at 0x4, far_end at 0x8; write them only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_disk_request_order_core #(
  parameter int unsigned MAX_REQUESTS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // request words
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire sdro_pkg::in_word_t          in_word_i,
  // path words
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      sdro_pkg::out_word_t         out_word_o,
  // register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sdro_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sdro_pkg::DATA_W-1:0] pwdata,
  output      logic [sdro_pkg::DATA_W-1:0] prdata,
  output      logic                        pready
);

  logic [sdro_pkg::POS_W-1:0] start_pos_q, far_end_q;
  logic                       sweep_up_q;
  logic [1:0]                 reg_idx;
  logic                       reg_wr;

  logic             push, full, pop, empty;
  sdro_pkg::visit_t push_visit, head_visit;

  // Register port: pready is always high, word index from paddr[3:2]
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pos_q <= sdro_pkg::START_POS_RST;
      sweep_up_q  <= sdro_pkg::SWEEP_UP_RST;
      far_end_q   <= sdro_pkg::FAR_END_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        sdro_pkg::REG_START_POS: start_pos_q <= pwdata[sdro_pkg::POS_W-1:0];
        sdro_pkg::REG_SWEEP_UP:  sweep_up_q  <= pwdata[0];
        sdro_pkg::REG_FAR_END:   far_end_q   <= pwdata[sdro_pkg::POS_W-1:0];
        default: begin
          // drop writes to unmapped words
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sdro_pkg::REG_START_POS:
        prdata = {{(sdro_pkg::DATA_W - sdro_pkg::POS_W){1'b0}}, start_pos_q};
      sdro_pkg::REG_SWEEP_UP:
        prdata = {{(sdro_pkg::DATA_W - 1){1'b0}}, sweep_up_q};
      sdro_pkg::REG_FAR_END:
        prdata = {{(sdro_pkg::DATA_W - sdro_pkg::POS_W){1'b0}}, far_end_q};
      default:
        prdata = '0;
    endcase
  end

  // Front: load, sort on arrival, split and sequence the visits
  sdro_front #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .start_pos_i(start_pos_q),
    .sweep_up_i (sweep_up_q),
    .far_end_i  (far_end_q),
    .push_o     (push),
    .visit_o    (push_visit),
    .full_i     (full)
  );

  // Hold up to two visits so each side stalls on its own
  sdro_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .visit_i(push_visit),
    .full_o (full),
    .pop_i  (pop),
    .visit_o(head_visit),
    .empty_o(empty)
  );

  // Back: accumulate seek distance and present result words
  sdro_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .visit_i    (head_visit),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

FILE: sv/sdro_checker.sv
// ----------------------------------------------------------------------------
// sdro_checker - port-level checks of the SCAN request ordering core
// Watches both channels and flags handshake and path-sum violations.
// ----------------------------------------------------------------------------
`default_nettype none

module sdro_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire sdro_pkg::in_word_t  in_word_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire sdro_pkg::out_word_t out_word_o
);

  logic                       out_acc, exp_first_q;
  logic [sdro_pkg::SUM_W-1:0] last_sum_q;

  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_first_q <= 1'b1;
      last_sum_q  <= '0;
    end else if (out_acc) begin
      exp_first_q <= out_word_o.path_end;
      last_sum_q  <= out_word_o.seek_total;
    end
  end

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("result word changed while stalled");

  // Stall input after the closing word of a batch
  a_batch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_word_i.batch_end) |=> in_stall_o)
    else $error("input not stalled after batch end");

  // Start every path with a zero seek total
  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && exp_first_q) |-> (out_word_o.seek_total == '0))
    else $error("path does not start with zero seek total");

  // Never let the seek total fall within a path
  a_sum_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !exp_first_q) |-> (out_word_o.seek_total >= last_sum_q))
    else $error("seek total decreased within a path");

endmodule

bind scan_disk_request_order_core sdro_checker u_sdro_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_word_i  (in_word_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);

`default_nettype wire
